// ===== rtl/core/r2q_pkg.sv =====
// ----------------------------------------------------------------------------
// r2q_pkg: shared types and constants for the matrix-to-quaternion converter
// Fixed-point format, pipeline widths and the stage payload structs.
// ----------------------------------------------------------------------------
package r2q_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;

  // Radicands reach 1 + 3*2^15 in Q.14, so 19 bits hold every one.
  localparam int RW  = 20;
  // Square-root operand is rad << (FRAC_BITS-2).
  localparam int SOW = RW + FRAC_BITS - 2;
  localparam int SQW = (SOW + 1) / 2;
  // Off-diagonal sum or difference: 17 bits signed, 17 bits magnitude.
  localparam int NW  = DW + 1;
  // Dividend magnitude is |n| << FRAC_BITS, plus a half divisor.
  localparam int DVW = NW + FRAC_BITS + 1;
  localparam int DEN_W = SQW + 2;

  // Side payload of the square root: six off-diagonal terms and the pivot.
  localparam int SQ_SIDE_W = 6 * NW + 2;
  // Side payload of the divider: root, six signs and the pivot.
  localparam int DV_SIDE_W = SQW + 8;

  localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FRAC_BITS);

  typedef logic [1:0] pivot_t;

  typedef struct packed {
    logic signed [DW-1:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
  } mat_t;

  typedef struct packed {
    logic signed [DW-1:0] qx, qy, qz, qw;
    pivot_t               pivot;
  } quat_t;

  function automatic logic signed [DW-1:0] sat_one(input logic signed [DVW:0] v);
    logic signed [DVW:0] one_ext;
    begin
      one_ext = (DVW+1)'(1 << FRAC_BITS);
      if (v > one_ext) sat_one = ONE_Q;
      else if (v < -one_ext) sat_one = -ONE_Q;
      else sat_one = v[DW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/r2q_if.sv =====
// ----------------------------------------------------------------------------
// r2q_in_if / r2q_out_if: valid/ready channels of the converter
// Request channels carrying a matrix in and a quaternion out.
// ----------------------------------------------------------------------------
interface r2q_in_if;
  logic          valid;
  logic          ready;
  r2q_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface r2q_out_if;
  logic           valid;
  logic           ready;
  r2q_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd conversion of a DCM to a quaternion
// ----------------------------------------------------------------------------
// A matrix request enters on in_ch (nine Q1.14 elements) and one quaternion
// request leaves on out_ch (qx, qy, qz, qw in Q1.14 and the pivot index).
// The pipeline takes one matrix per clock cycle unless the output stalls.
// An accepted item passes the radicand, compare and pick stages, the square
// root, the dividend stage, the divider and the output register; the root
// resolves one root bit per stage and the divider one quotient bit per stage.
// The whole pipeline advances as one: while the output register is full and
// the receiver holds ready low, every stage holds, and in_ready is low.
// A bubble-free stall therefore costs nothing and drops or repeats no item.
// Synchronous active-low reset clears all valid bits; data registers are
// left as they are. There is no configuration and no state between items.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic clk,
  input  logic rst_n,
  r2q_in_if.sink    in_ch,
  r2q_out_if.source out_ch
);
  import r2q_pkg::*;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: radicands and off-diagonal sums and differences.
  logic                  s1_vld_r;
  logic signed [RW-1:0]  s1_rad_r [4];
  logic signed [NW-1:0]  s1_sd_r  [6];
  logic signed [RW-1:0]  tr, rad_nxt [4];
  mat_t m;

  always_comb begin
    m = in_ch.data;
    tr = RW'(m.c00) + RW'(m.c11) + RW'(m.c22);
    rad_nxt[0] = RW'(RW'(ONE_Q) + 2 * RW'(m.c00) - tr);
    rad_nxt[1] = RW'(RW'(ONE_Q) + 2 * RW'(m.c11) - tr);
    rad_nxt[2] = RW'(RW'(ONE_Q) + 2 * RW'(m.c22) - tr);
    rad_nxt[3] = RW'(ONE_Q) + tr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_rad_r[i] <= rad_nxt[i][RW-1] ? '0 : rad_nxt[i];
      end
      s1_sd_r[0] <= NW'(m.c01) + NW'(m.c10);
      s1_sd_r[1] <= NW'(m.c12) + NW'(m.c21);
      s1_sd_r[2] <= NW'(m.c20) + NW'(m.c02);
      s1_sd_r[3] <= NW'(m.c12) - NW'(m.c21);
      s1_sd_r[4] <= NW'(m.c20) - NW'(m.c02);
      s1_sd_r[5] <= NW'(m.c01) - NW'(m.c10);
    end
  end

  // Stage 2: pairwise compare.
  logic                 s2_vld_r;
  logic signed [RW-1:0] s2_a_r, s2_b_r;
  logic                 s2_ia_r, s2_ib_r;
  logic [6*NW-1:0]      s2_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      if (s1_rad_r[1] > s1_rad_r[0]) begin
        s2_a_r <= s1_rad_r[1]; s2_ia_r <= 1'b1;
      end else begin
        s2_a_r <= s1_rad_r[0]; s2_ia_r <= 1'b0;
      end
      if (s1_rad_r[3] > s1_rad_r[2]) begin
        s2_b_r <= s1_rad_r[3]; s2_ib_r <= 1'b1;
      end else begin
        s2_b_r <= s1_rad_r[2]; s2_ib_r <= 1'b0;
      end
      s2_sd_r <= {s1_sd_r[5], s1_sd_r[4], s1_sd_r[3],
                  s1_sd_r[2], s1_sd_r[1], s1_sd_r[0]};
    end
  end

  // Stage 3: final pick; lower index wins ties.
  logic                 s3_vld_r;
  logic [RW-1:0]        s3_rad_r;
  pivot_t               s3_piv_r;
  logic [6*NW-1:0]      s3_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      if (s2_b_r > s2_a_r) begin
        s3_rad_r <= s2_b_r; s3_piv_r <= {1'b1, s2_ib_r};
      end else begin
        s3_rad_r <= s2_a_r; s3_piv_r <= {1'b0, s2_ia_r};
      end
      s3_sd_r <= s2_sd_r;
    end
  end

  logic                 sq_vld;
  logic [SQW-1:0]       sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;

  r2q_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s3_vld_r),
    .in_op   ({s3_rad_r, (FRAC_BITS-2)'(0)}),
    .in_side ({s3_sd_r, s3_piv_r}),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_side)
  );

  // Stage after root: dividend magnitudes with half the divisor added.
  logic                     s4_vld_r;
  logic [5:0][DVW-1:0]      s4_num_r;
  logic [DEN_W-1:0]         s4_den_r;
  logic [DV_SIDE_W-1:0]     s4_side_r;
  logic [DEN_W-1:0]         den_c;

  always_comb den_c = {sq_root, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld;
    end
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        logic signed [NW-1:0] n;
        logic [NW-1:0]        mag;
        n   = sq_side[2 + l*NW +: NW];
        mag = n[NW-1] ? NW'(-n) : NW'(n);
        s4_num_r[l]  <= DVW'({mag, (FRAC_BITS)'(0)}) + DVW'(den_c >> 1);
        s4_side_r[2 + l] <= n[NW-1];
      end
      s4_den_r  <= den_c;
      s4_side_r[1:0] <= sq_side[1:0];
      s4_side_r[SQW+7:8] <= sq_root;
    end
  end

  logic                  dv_vld;
  logic [5:0][DVW-1:0]   dv_quo;
  logic [DV_SIDE_W-1:0]  dv_side;

  r2q_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s4_vld_r),
    .in_num  (s4_num_r),
    .in_den  (s4_den_r),
    .in_side (s4_side_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_side(dv_side)
  );

  // Output stage: sign, select, saturate.
  logic signed [DVW:0] sd [6];
  logic signed [DVW:0] e_s;
  quat_t               res_nxt;
  quat_t               res_r;
  logic                out_vld_r;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      sd[l] = dv_side[2 + l] ? -(DVW+1)'(dv_quo[l]) : (DVW+1)'(dv_quo[l]);
    end
    e_s = (DVW+1)'(dv_side[SQW+7:8]);
    res_nxt.pivot = dv_side[1:0];
    case (dv_side[1:0])
      2'd0: begin
        res_nxt.qx = sat_one(e_s);   res_nxt.qy = sat_one(sd[0]);
        res_nxt.qz = sat_one(sd[2]); res_nxt.qw = sat_one(sd[3]);
      end
      2'd1: begin
        res_nxt.qx = sat_one(sd[0]); res_nxt.qy = sat_one(e_s);
        res_nxt.qz = sat_one(sd[1]); res_nxt.qw = sat_one(sd[4]);
      end
      2'd2: begin
        res_nxt.qx = sat_one(sd[2]); res_nxt.qy = sat_one(sd[1]);
        res_nxt.qz = sat_one(e_s);   res_nxt.qw = sat_one(sd[5]);
      end
      default: begin
        res_nxt.qx = sat_one(sd[3]); res_nxt.qy = sat_one(sd[4]);
        res_nxt.qz = sat_one(sd[5]); res_nxt.qw = sat_one(e_s);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = res_r;
endmodule

// ===== rtl/core/r2q_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// r2q_sqrt_pipe: pipelined integer square root
// One result bit per stage; a side payload travels with each operand.
// ----------------------------------------------------------------------------
module r2q_sqrt_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [r2q_pkg::SOW-1:0]       in_op,
  input  logic [r2q_pkg::SQ_SIDE_W-1:0] in_side,
  output logic                          out_vld,
  output logic [r2q_pkg::SQW-1:0]       out_root,
  output logic [r2q_pkg::SQ_SIDE_W-1:0] out_side
);
  import r2q_pkg::*;

  localparam int N  = SQW;
  localparam int OW = 2 * N;

  logic [OW-1:0]        rem_r  [N+1];
  logic [N-1:0]         root_r [N+1];
  logic [OW-1:0]        op_r   [N+1];
  logic [SQ_SIDE_W-1:0] side_r [N+1];
  logic [N:0]           vld_r;

  always_comb begin
    rem_r[0]  = '0;
    root_r[0] = '0;
    op_r[0]   = OW'(in_op);
    side_r[0] = in_side;
    vld_r[0]  = in_vld;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [OW+1:0] trial_nxt;
    logic [OW+1:0] rem_sh;
    always_comb begin
      rem_sh    = {rem_r[s], op_r[s][OW-1 -: 2]};
      trial_nxt = (OW+2)'({root_r[s], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        if (rem_sh >= trial_nxt) begin
          rem_r[s+1]  <= OW'(rem_sh - trial_nxt);
          root_r[s+1] <= {root_r[s][N-2:0], 1'b1};
        end else begin
          rem_r[s+1]  <= OW'(rem_sh);
          root_r[s+1] <= {root_r[s][N-2:0], 1'b0};
        end
        op_r[s+1]   <= {op_r[s][OW-3:0], 2'b00};
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];
endmodule

// ===== rtl/core/r2q_div_pipe.sv =====
// ----------------------------------------------------------------------------
// r2q_div_pipe: pipelined restoring divider, six lanes sharing one divisor
// One quotient bit per stage for each lane, with side payload alongside.
// ----------------------------------------------------------------------------
module r2q_div_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [5:0][r2q_pkg::DVW-1:0]  in_num,
  input  logic [r2q_pkg::DEN_W-1:0]     in_den,
  input  logic [r2q_pkg::DV_SIDE_W-1:0] in_side,
  output logic                          out_vld,
  output logic [5:0][r2q_pkg::DVW-1:0]  out_quo,
  output logic [r2q_pkg::DV_SIDE_W-1:0] out_side
);
  import r2q_pkg::*;

  localparam int N = DVW;

  logic [5:0][DEN_W-1:0] rem_r  [N+1];
  logic [5:0][N-1:0]     quo_r  [N+1];
  logic [DEN_W-1:0]      den_r  [N+1];
  logic [DV_SIDE_W-1:0]  side_r [N+1];
  logic [N:0]            vld_r;

  always_comb begin
    rem_r[0]  = '0;
    quo_r[0]  = in_num;
    den_r[0]  = in_den;
    side_r[0] = in_side;
    vld_r[0]  = in_vld;
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  for (genvar s = 0; s < N; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
    for (genvar l = 0; l < 6; l++) begin : g_lane
      logic [DEN_W:0] part;
      always_comb part = {rem_r[s][l], quo_r[s][l][N-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (part >= {1'b0, den_r[s]}) begin
            rem_r[s+1][l] <= DEN_W'(part - {1'b0, den_r[s]});
            quo_r[s+1][l] <= {quo_r[s][l][N-2:0], 1'b1};
          end else begin
            rem_r[s+1][l] <= DEN_W'(part);
            quo_r[s+1][l] <= {quo_r[s][l][N-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_quo  = quo_r[N];
  assign out_side = side_r[N];
endmodule

// ===== rtl/core/r2q_checker.sv =====
// ----------------------------------------------------------------------------
// r2q_checker: port-level checks of the converter
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module r2q_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input r2q_pkg::quat_t out_data
);
  import r2q_pkg::*;

  // A waiting result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input is open exactly when the output can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // Components qx and qw never leave [-1.0, +1.0].
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.qx <= ONE_Q && out_data.qx >= -ONE_Q &&
                   out_data.qw <= ONE_Q && out_data.qw >= -ONE_Q))
    else $error("component out of range");

  // No result comes out right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind rotation_matrix_to_quaternion r2q_checker u_r2q_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);

// ===== test/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: self-checking bench for the converter
// Matrix requests go in from a stimulus table and then at random. Each one is
// predicted in fixed point, and the expected quaternion is queued. Returning
// quaternion requests are checked in order against that queue. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  import r2q_pkg::*;

  localparam int NUM_RANDOM  = 1600;
  localparam int WATCHDOG    = 2000;
  localparam int DRAIN       = 80;

  logic clk;
  logic rst_n;

  r2q_in_if  in_ch ();
  r2q_out_if out_ch ();

  rotation_matrix_to_quaternion uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  typedef struct {
    mat_t  m;
    logic  known;
    quat_t q;
  } stim_row_t;

  quat_t     quat_expected[$];
  stim_row_t stim_table[$];
  int        mismatches;
  int        idle_cycles;
  logic      out_calm;
  int        stall_left;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Quotient of n * 2^FRAC_BITS by d, rounded to nearest, halves away from zero.
  function automatic longint quarter_div(input longint n, input longint d);
    longint unsigned mag;
    longint unsigned qt;
    if (d <= 0) return 0;
    mag = longint'(n < 0 ? -n : n) << FRAC_BITS;
    qt  = (mag + d / 2) / d;
    return n < 0 ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic logic signed [DW-1:0] clamp_unit(input longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[DW-1:0];
  endfunction

  function automatic quat_t shepperd(input mat_t m);
    longint c[9];
    longint rad[4];
    longint sd[6];
    longint qv[4];
    longint tr, e, den, one;
    int p;
    quat_t r;
    c = '{m.c00, m.c01, m.c02, m.c10, m.c11, m.c12, m.c20, m.c21, m.c22};
    one = longint'(1) << FRAC_BITS;
    tr = c[0] + c[4] + c[8];
    rad[0] = one + 2 * c[0] - tr;
    rad[1] = one + 2 * c[4] - tr;
    rad[2] = one + 2 * c[8] - tr;
    rad[3] = one + tr;
    for (int i = 0; i < 4; i++) if (rad[i] < 0) rad[i] = 0;
    p = 0;
    for (int i = 1; i < 4; i++) if (rad[i] > rad[p]) p = i;
    e = longint'(root_floor(longint'(rad[p]) << (FRAC_BITS - 2)));
    den = 4 * e;
    sd[0] = quarter_div(c[1] + c[3], den);
    sd[1] = quarter_div(c[5] + c[7], den);
    sd[2] = quarter_div(c[6] + c[2], den);
    sd[3] = quarter_div(c[5] - c[7], den);
    sd[4] = quarter_div(c[6] - c[2], den);
    sd[5] = quarter_div(c[1] - c[3], den);
    case (p)
      0: qv = '{e, sd[0], sd[2], sd[3]};
      1: qv = '{sd[0], e, sd[1], sd[4]};
      2: qv = '{sd[2], sd[1], e, sd[5]};
      default: qv = '{sd[3], sd[4], sd[5], e};
    endcase
    r.qx = clamp_unit(qv[0]);
    r.qy = clamp_unit(qv[1]);
    r.qz = clamp_unit(qv[2]);
    r.qw = clamp_unit(qv[3]);
    r.pivot = pivot_t'(p);
    return r;
  endfunction

  function automatic mat_t diag_mat(input int a, input int b, input int d);
    mat_t m;
    m = '0;
    m.c00 = DW'(a);
    m.c11 = DW'(b);
    m.c22 = DW'(d);
    return m;
  endfunction

  function automatic logic signed [DW-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return DW'($urandom);
      1: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
      default: return DW'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // A proper rotation from a random unit quaternion, so every pivot comes up.
  function automatic mat_t rand_rotation();
    real a, b, cc, d, n, s;
    mat_t m;
    a = real'(int'($urandom_range(0, 2000)) - 1000);
    b = real'(int'($urandom_range(0, 2000)) - 1000);
    cc = real'(int'($urandom_range(0, 2000)) - 1000);
    d = real'(int'($urandom_range(0, 2000)) - 1000);
    n = a * a + b * b + cc * cc + d * d;
    if (n == 0.0) begin
      d = 1.0;
      n = 1.0;
    end
    s = 16384.0 / n;
    m.c00 = DW'($rtoi(s * (d * d + a * a - b * b - cc * cc)));
    m.c11 = DW'($rtoi(s * (d * d - a * a + b * b - cc * cc)));
    m.c22 = DW'($rtoi(s * (d * d - a * a - b * b + cc * cc)));
    m.c01 = DW'($rtoi(s * 2.0 * (a * b + cc * d)));
    m.c10 = DW'($rtoi(s * 2.0 * (a * b - cc * d)));
    m.c02 = DW'($rtoi(s * 2.0 * (a * cc - b * d)));
    m.c20 = DW'($rtoi(s * 2.0 * (a * cc + b * d)));
    m.c12 = DW'($rtoi(s * 2.0 * (b * cc + a * d)));
    m.c21 = DW'($rtoi(s * 2.0 * (b * cc - a * d)));
    return m;
  endfunction

  function automatic quat_t quat_of(input int x, input int y, input int z, input int w,
                                    input int p);
    quat_t q;
    q.qx = DW'(x);
    q.qy = DW'(y);
    q.qz = DW'(z);
    q.qw = DW'(w);
    q.pivot = pivot_t'(p);
    return q;
  endfunction

  task automatic add_row(input mat_t m, input logic known, input quat_t q);
    stim_row_t r;
    r.m = m;
    r.known = known;
    r.q = q;
    stim_table.push_back(r);
  endtask

  task automatic build_table();
    mat_t m;
    // Identity gives the scalar pivot, w = 1.0.
    add_row(diag_mat(16384, 16384, 16384), 1'b1, quat_of(0, 0, 0, 16384, 3));
    // Half-turns about each axis pick the vector pivots.
    add_row(diag_mat(16384, -16384, -16384), 1'b1, quat_of(16384, 0, 0, 0, 0));
    add_row(diag_mat(-16384, 16384, -16384), 1'b1, quat_of(0, 16384, 0, 0, 1));
    add_row(diag_mat(-16384, -16384, 16384), 1'b1, quat_of(0, 0, 16384, 0, 2));
    // Zero matrix: all four radicands tie, the lowest index wins.
    add_row(diag_mat(0, 0, 0), 1'b1, quat_of(8192, 0, 0, 0, 0));
    // All diagonals at -1 drive the scalar radicand negative.
    add_row(diag_mat(-16384, -16384, -16384), 1'b0, '0);
    // Most negative elements everywhere, and all ones in the bit pattern.
    m = {9{16'sh8000}};
    add_row(m, 1'b0, '0);
    m = {9{16'shFFFF}};
    add_row(m, 1'b0, '0);
    m = {9{16'sh7FFF}};
    add_row(m, 1'b0, '0);
    m = {9{16'sh4000}};
    add_row(m, 1'b0, '0);
    m = {9{16'shC000}};
    add_row(m, 1'b0, '0);
    // Large off-diagonals with a small pivot saturate the quotients.
    m = diag_mat(16384, 16384, 16384);
    m.c12 = 16'sh7FFF;
    m.c21 = 16'sh8000;
    m.c01 = 16'sh7FFF;
    m.c10 = 16'sh8001;
    add_row(m, 1'b0, '0);
    m = diag_mat(0, 0, 0);
    m.c01 = 16'sh7FFF;
    m.c10 = 16'sh7FFF;
    m.c02 = 16'sh8000;
    m.c20 = 16'sh8000;
    add_row(m, 1'b0, '0);
    // Off-diagonal terms of 1, -3 and 5 give quotients with quarter fractions for the rounding rule.
    m = diag_mat(16384, 16384, 16384);
    m.c12 = 16'sd1;
    m.c20 = -16'sd3;
    m.c01 = 16'sd5;
    add_row(m, 1'b0, '0);
    for (int i = 0; i < 6; i++) add_row(rand_rotation(), 1'b0, '0);
  endtask

  task automatic send_matrix(input mat_t m, input logic gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quat_expected.push_back(shepperd(m));
  endtask

  // Receiver stalls in random bursts until the calm tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= stall_left == 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(1, 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quat_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %p", out_ch.data);
      end else begin
        want = quat_expected.pop_front();
        if (out_ch.data.qx !== want.qx || out_ch.data.qy !== want.qy ||
            out_ch.data.qz !== want.qz || out_ch.data.qw !== want.qw ||
            out_ch.data.pivot !== want.pivot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t r;
    quat_t want;
    mismatches = 0;
    out_calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    build_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_table[i]) begin
      r = stim_table[i];
      if (r.known) begin
        want = shepperd(r.m);
        if (want !== r.q) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d: %p vs %p", i, r.q, want);
        end
      end
      send_matrix(r.m, 1'b1);
    end
    // Hold the sender back until the pipeline is empty.
    in_ch.valid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mat_t m;
      if (i >= NUM_RANDOM - 200) out_calm = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        m = rand_rotation();
      end else begin
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
      end
      send_matrix(m, i < NUM_RANDOM - 200);
    end
    in_ch.valid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && quat_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
